// ----- rtl/plist_pkg.sv -----
// ----------------------------------------------------------------------------
// plist_pkg
// shared types and constants for the positional list block
// ----------------------------------------------------------------------------
package plist_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int POS_W     = 7;
    localparam int DATA_W    = 32;

    // opcodes of an input item
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_DUMP   = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_BADPOS = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    typedef struct packed {
        logic [1:0]              opcode;
        logic [POS_W-1:0]        position;
        logic signed [DATA_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] element;
        logic                     is_last;
        logic [1:0]               status;
    } out_item_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_ROTATE
    } cell_op_t;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        cell_op_t                 op;
        logic [POS_W-1:0]         pos;
        logic [POS_W-1:0]         last;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] head;
    } cell_ctrl_t;

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } state_t;

endpackage

// ----- rtl/plist_cell.sv -----
// ----------------------------------------------------------------------------
// plist_cell
// one list slot: holds a value, takes a neighbor's value on a shift
// ----------------------------------------------------------------------------
module plist_cell #(
    parameter int IDX = 0
) (
    input  logic                               clk,
    input  plist_pkg::cell_ctrl_t              ctrl,
    input  logic signed [plist_pkg::DATA_W-1:0] left_data,
    input  logic signed [plist_pkg::DATA_W-1:0] right_data,
    output logic signed [plist_pkg::DATA_W-1:0] data
);
    import plist_pkg::*;

    localparam logic [POS_W-1:0] SLOT      = POS_W'(IDX);
    localparam logic [POS_W-1:0] SLOT_NEXT = POS_W'(IDX + 1);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.op)
            CELL_INSERT:
            begin
                if (SLOT == ctrl.pos)
                    data_next = ctrl.value;
                else if (SLOT > ctrl.pos)
                    data_next = left_data;
            end
            CELL_DELETE:
            begin
                // slots from the removed one onward pull from the right
                if (SLOT_NEXT >= ctrl.pos)
                    data_next = right_data;
            end
            CELL_ROTATE:
            begin
                // tail slot wraps the head around
                if (SLOT == ctrl.last)
                    data_next = ctrl.head;
                else
                    data_next = right_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ----- rtl/positional_list_insert_delete.sv -----
// ----------------------------------------------------------------------------
// positional_list_insert_delete
// ordered list of signed values kept in a row of shifting cells
// ----------------------------------------------------------------------------
//  channel | direction | payload    | handshake
//  in      | input     | in_item_t  | in_valid / in_ready
//  out     | output    | out_item_t | out_valid / out_ready
//
//  insert, delete and an empty dump are answered on accept: the affected cells
//  shift at once and one status item lands in the output register
//  a dump is accepted, then emits one element per cycle while the output
//  register is free, rotating the row toward the head; input is held off until
//  the last loads; a stalled output register stops the dump and input alike
//  reset clears the element count and control; cell contents stay unknown
// ----------------------------------------------------------------------------
module positional_list_insert_delete #(
    parameter int DEPTH = plist_pkg::DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  plist_pkg::in_item_t  in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output plist_pkg::out_item_t out_item
);
    import plist_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    // list bookkeeping
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] dump_idx_reg, dump_idx_next;
    state_t           state_reg, state_next;

    // output register
    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg, out_item_next;

    logic in_fire;
    logic out_free;
    logic dump_last;

    cell_ctrl_t               cell_ctrl;
    logic signed [DATA_W-1:0] cell_q [DEPTH];

    // row of cells, head at slot 0
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] left_d;
        logic signed [DATA_W-1:0] right_d;

        if (i == 0)
        begin : g_head
            assign left_d = cell_q[0];
        end
        else
        begin : g_mid_l
            assign left_d = cell_q[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_d = cell_q[i];
        end
        else
        begin : g_mid_r
            assign right_d = cell_q[i+1];
        end

        plist_cell #(
            .IDX (i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_q[i])
        );
    end

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && out_free;
    assign in_fire   = in_valid && in_ready;
    assign dump_last = (CNT_W'(dump_idx_reg + 1'b1) == count_reg);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        dump_idx_next  = dump_idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_item_next  = out_item_reg;

        cell_ctrl.op    = CELL_HOLD;
        cell_ctrl.pos   = in_item.position;
        cell_ctrl.last  = POS_W'(count_reg) - POS_W'(1);
        cell_ctrl.value = in_item.value;
        cell_ctrl.head  = cell_q[0];

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    // status items carry a zero element and end the item
                    out_item_next.element = '0;
                    out_item_next.is_last = 1'b1;
                    out_item_next.status  = ST_OK;
                    case (in_item.opcode)
                        OP_INSERT:
                        begin
                            out_valid_next = 1'b1;
                            // full check comes before the position check
                            if (count_reg == CNT_W'(DEPTH))
                                out_item_next.status = ST_FULL;
                            else if (in_item.position > POS_W'(count_reg))
                                out_item_next.status = ST_BADPOS;
                            else
                            begin
                                cell_ctrl.op = CELL_INSERT;
                                count_next   = count_reg + 1'b1;
                            end
                        end
                        OP_DELETE:
                        begin
                            out_valid_next = 1'b1;
                            if (in_item.position == '0 ||
                                in_item.position > POS_W'(count_reg))
                                out_item_next.status = ST_BADPOS;
                            else
                            begin
                                cell_ctrl.op = CELL_DELETE;
                                count_next   = count_reg - 1'b1;
                            end
                        end
                        OP_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                out_valid_next       = 1'b1;
                                out_item_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                state_next    = S_DUMP;
                                dump_idx_next = '0;
                            end
                        end
                        default:
                        begin
                            // unused opcode: dropped without a result
                            out_item_next = out_item_reg;
                        end
                    endcase
                end
            end
            S_DUMP:
            begin
                if (out_free)
                begin
                    // emit the head, rotate so the next element reaches slot 0;
                    // after count rotations the order is as before
                    out_valid_next        = 1'b1;
                    out_item_next.element = cell_q[0];
                    out_item_next.is_last = dump_last;
                    out_item_next.status  = ST_OK;
                    cell_ctrl.op          = CELL_ROTATE;
                    dump_idx_next         = dump_idx_reg + 1'b1;
                    if (dump_last)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            dump_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dump_idx_reg  <= dump_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ----- rtl/plist_check.sv -----
// ----------------------------------------------------------------------------
// plist_check
// port-level checks for the positional list block
// ----------------------------------------------------------------------------
module plist_check (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input plist_pkg::in_item_t  in_item,
    input logic                 out_valid,
    input logic                 out_ready,
    input plist_pkg::out_item_t out_item
);
    import plist_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("stalled result changed");

    // status results carry a zero element and end their item
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.status != ST_OK |->
            out_item.element == '0 && out_item.is_last)
        else $error("non-ok result malformed");

    // insert and delete answer in the next cycle with one final result
    a_edit_answer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready &&
            (in_item.opcode == OP_INSERT || in_item.opcode == OP_DELETE) |=>
            out_valid && out_item.is_last &&
            (out_item.status == ST_OK || out_item.status == ST_FULL ||
             out_item.status == ST_BADPOS))
        else $error("edit item not answered");

    // input is held off while a dump is unfinished
    a_dump_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.is_last |-> !in_ready)
        else $error("input taken during dump");

endmodule

bind positional_list_insert_delete plist_check u_plist_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the positional list: directed corners, then random
// insert, delete and dump traffic under several idle and stall mixes, with a
// queue-based predictor of the list and an in-order check of every result item
// ----------------------------------------------------------------------------
module tb;

    import plist_pkg::*;

    // the one opcode the block ignores
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // cycles with no item moving on either side before the run is declared hung
    localparam int HANG_LIMIT = 2000;

    // ------------------------------------------------------------------------
    // list predictor and result scoreboard
    // ------------------------------------------------------------------------
    class list_scoreboard;
        logic signed [DATA_W-1:0] cells[$];    // head at index 0
        out_item_t                due_q[$];    // results still owed, oldest first
        int unsigned              mismatches;

        function void owe(logic signed [DATA_W-1:0] element, logic is_last,
                          logic [1:0] status);
            out_item_t r;
            r.element = element;
            r.is_last = is_last;
            r.status  = status;
            due_q.push_back(r);
        endfunction

        // apply one accepted input item to the list and queue its results
        function void note_input(in_item_t it);
            int cnt;
            cnt = cells.size();
            case (it.opcode)
                OP_INSERT:
                begin
                    // full check wins over the position check
                    if (cnt >= DEPTH_DEF)
                        owe('0, 1'b1, ST_FULL);
                    else if (it.position > cnt)
                        owe('0, 1'b1, ST_BADPOS);
                    else
                    begin
                        cells.insert(it.position, it.value);
                        owe('0, 1'b1, ST_OK);
                    end
                end
                OP_DELETE:
                begin
                    if (it.position == 0 || it.position > cnt)
                        owe('0, 1'b1, ST_BADPOS);
                    else
                    begin
                        cells.delete(it.position - 1);
                        owe('0, 1'b1, ST_OK);
                    end
                end
                OP_DUMP:
                begin
                    if (cnt == 0)
                        owe('0, 1'b1, ST_EMPTY);
                    else
                        foreach (cells[k])
                            owe(cells[k], k == cnt - 1, ST_OK);
                end
                default: ;  // unused opcode: no result, list untouched
            endcase
        endfunction

        function void report(string what, out_item_t want, out_item_t got);
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("%0t: %s: expected element=%0d is_last=%0b status=%0d",
                         $time, what, want.element, want.is_last, want.status);
                $display("    got element=%0d is_last=%0b status=%0d",
                         got.element, got.is_last, got.status);
            end
        endfunction

        // compare one accepted result item with the oldest one owed
        function void check_result(out_item_t got);
            out_item_t want;
            if (due_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result element=%0d is_last=%0b status=%0d",
                             $time, got.element, got.is_last, got.status);
                return;
            end
            want = due_q.pop_front();
            if (got.element !== want.element || got.is_last !== want.is_last ||
                got.status !== want.status)
                report("result mismatch", want, got);
        endfunction

        function int pending();
            return due_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block under test
    // ------------------------------------------------------------------------
    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_item;

    list_scoreboard sb;

    int  idle_pct;     // chance in a hundred that the sender idles a cycle
    int  stall_pct;    // chance in a hundred that the receiver stalls a cycle
    bit  grow;         // random traffic trend: fill the list or drain it

    initial clk = 1'b0;
    always #10 clk = ~clk;

    positional_list_insert_delete DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // ------------------------------------------------------------------------
    // receiver side: random back-pressure, results checked as they are taken
    // ------------------------------------------------------------------------
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_item);

    // ------------------------------------------------------------------------
    // hang watchdog: counts cycles in which no item moves on either side
    // ------------------------------------------------------------------------
    initial
    begin
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < HANG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------------
    function automatic in_item_t make_item(logic [1:0] op, int pos,
                                           logic signed [DATA_W-1:0] val);
        in_item_t it;
        it.opcode   = op;
        it.position = pos[POS_W-1:0];
        it.value    = val;
        return it;
    endfunction

    // present one item, with a random gap first, and hold it until taken;
    // valid is only lowered when a gap follows, so it never toggles in one step
    task automatic send_item(input in_item_t it);
        int gap;
        gap = 0;
        while (gap < 30 && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(it);
    endtask

    // hold the sender off until every owed result has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // random value biased toward the two extremes
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(7))
            0:       return {1'b0, {(DATA_W-1){1'b1}}};
            1:       return {1'b1, {(DATA_W-1){1'b0}}};
            default: return $urandom;
        endcase
    endfunction

    // random traffic: mostly legal positions against the current list length,
    // trending toward full and back to empty so both ends get exercised
    task automatic run_random(input int n);
        int         sent;
        int         cnt;
        int         r;
        int         pos;
        logic [1:0] op;
        sent = 0;
        while (sent < n)
        begin
            cnt = sb.cells.size();
            if (cnt == 0)
                grow = 1'b1;
            else if (cnt == DEPTH_DEF && $urandom_range(3) == 0)
                grow = 1'b0;

            r = $urandom_range(99);
            if (r < 3)
                op = OP_UNUSED;
            else if (r < 10)
                op = OP_DUMP;
            else if (grow ? (r < 78) : (r < 28))
                op = OP_INSERT;
            else
                op = OP_DELETE;

            // roughly one in ten positions is raw noise over the full field
            if ($urandom_range(9) == 0)
                pos = $urandom_range((1 << POS_W) - 1);
            else if (op == OP_INSERT)
                pos = $urandom_range(cnt);
            else if (op == OP_DELETE && cnt > 0)
                pos = $urandom_range(cnt, 1);
            else
                pos = $urandom_range((1 << POS_W) - 1);

            send_item(make_item(op, pos, pick_value()));
            if (op != OP_UNUSED)
                sent++;
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        sb        = new();
        grow      = 1'b1;
        idle_pct  = 0;
        stall_pct = 0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_item   <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty list corners
        send_item(make_item(OP_DUMP,   0, 0));            // dump of empty list
        send_item(make_item(OP_DELETE, 1, 0));            // delete on empty list
        send_item(make_item(OP_DELETE, 0, 0));            // delete position zero
        send_item(make_item(OP_INSERT, 1, 5));            // insert past the end
        // directed: build head, tail and middle with extreme values
        send_item(make_item(OP_INSERT, 0, 32'sh7fffffff));
        send_item(make_item(OP_INSERT, 1, 32'sh80000000));
        send_item(make_item(OP_INSERT, 1, -1));
        send_item(make_item(OP_INSERT, 0, 0));
        send_item(make_item(OP_INSERT, 127, 32'sh55aa55aa));  // far past the end
        send_item(make_item(OP_UNUSED, 3, 32'sh12345678));    // ignored opcode
        send_item(make_item(OP_DUMP,   0, 0));
        // directed: delete tail, head and out of range
        send_item(make_item(OP_DELETE, 4, 0));
        send_item(make_item(OP_DELETE, 1, 0));
        send_item(make_item(OP_DELETE, 127, 0));
        send_item(make_item(OP_DELETE, 3, 0));            // one past the end
        send_item(make_item(OP_DUMP,   0, 0));
        send_item(make_item(OP_DELETE, 2, 0));
        send_item(make_item(OP_DELETE, 1, 0));
        send_item(make_item(OP_DUMP,   0, 0));            // empty again
        wait_drained();

        // random phases, each with its own idle and stall mix
        run_random(100);
        wait_drained();

        idle_pct = 69;
        run_random(100);
        wait_drained();

        idle_pct  = 0;
        stall_pct = 69;
        run_random(100);
        wait_drained();

        idle_pct  = 36;
        stall_pct = 36;
        run_random(100);
        wait_drained();

        // let any stray result show up before the verdict
        repeat (DEPTH_DEF + 8) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- positional_list_insert_delete.f -----
rtl/plist_pkg.sv
rtl/plist_cell.sv
rtl/positional_list_insert_delete.sv
rtl/plist_check.sv
dv/tb.sv
